// ===== hw/rtl/bswc_pkg.sv =====
// Shared types and constants for the bounded set with compaction.
package bswc_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int ELEM_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_MEMBER = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // per-cell update strobes
  typedef struct packed {
    logic load;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/bswc_cell.sv =====
// One storage cell of the set: holds an entry, compares it, shifts on removal.
module bswc_cell #(
  parameter int ELEMENT_WIDTH = bswc_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [ELEMENT_WIDTH-1:0] elem_i,
  input  logic [ELEMENT_WIDTH-1:0] next_i,
  input  logic                     valid_i,
  input  bswc_pkg::cell_ctl_t      ctl_i,
  input  logic                     prefix_i,
  output logic [ELEMENT_WIDTH-1:0] value_o,
  output logic                     match_o,
  output logic                     prefix_o
);
  import bswc_pkg::*;

  logic [ELEMENT_WIDTH-1:0] value_r;
  logic [ELEMENT_WIDTH-1:0] value_nxt;

  assign match_o  = valid_i && (value_r == elem_i);
  // a match here or in any earlier cell means this cell takes its neighbor
  assign prefix_o = prefix_i | match_o;
  assign value_o  = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl_i.load) begin
      value_nxt = elem_i;
    end else if (ctl_i.remove && prefix_o) begin
      value_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hw/rtl/bounded_set_with_compaction.sv =====
// Top level of the bounded set with compaction.
//
// Keeps up to CAPACITY distinct signed values, packed in insertion order in a
// row of register cells. Each input item (in_func, in_element, in_index) is
// an add, remove, membership query or indexed read. Every item gives exactly
// one result item: out_status, out_was_member, out_entry_count, out_read_value.
// All cells compare against the element in parallel; a remove shifts every
// cell at or after the match down by one, each taking its neighbor's value
// at the edge that accepts the item. That edge also loads the item's result
// into the output register, and the result is offered from the next cycle on.
// Throughput is one item per cycle while the receiver does not stall.
// Both channels hand items over on valid high and stall low. When the
// receiver stalls a held result, in_stall rises and no new item is taken
// until that result leaves. Synchronous active-low reset empties the set and
// clears out_valid; stored values are not cleared, since slots beyond the
// count are never read.
module bounded_set_with_compaction #(
  parameter int CAPACITY      = bswc_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = bswc_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bswc_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [bswc_pkg::ELEM_W-1:0]  in_element,
  input  logic [bswc_pkg::INDEX_W-1:0]        in_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bswc_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_was_member,
  output logic [bswc_pkg::COUNT_W-1:0]        out_entry_count,
  output logic signed [bswc_pkg::ELEM_W-1:0]  out_read_value
);
  import bswc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  logic             member_r;
  logic [COUNT_W-1:0] entry_count_r;
  logic signed [ELEM_W-1:0] read_value_r;

  logic accept;
  func_t func;
  logic signed [63:0] elem_ext;
  logic [ELEMENT_WIDTH-1:0] elem;

  logic [ELEMENT_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;
  logic [CAPACITY:0]        prefix;
  logic [CAPACITY-1:0]      cell_valid;
  cell_ctl_t                cell_ctl [CAPACITY];

  logic    member;
  logic    full;
  logic    add_ok;
  logic    remove_ok;
  logic    idx_ok;
  status_t status;
  logic [CMP_W-1:0] idx_ext;
  logic signed [ELEMENT_WIDTH-1:0] rd_sel;
  logic signed [63:0] rd_ext;
  logic signed [ELEM_W-1:0] read_value;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign func     = func_t'(in_func);
  assign elem_ext = 64'(in_element);
  assign elem     = elem_ext[ELEMENT_WIDTH-1:0];

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] next_val;

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    assign cell_valid[i]      = CNT_W'(i) < count_r;
    assign cell_ctl[i].load   = add_ok && (count_r == CNT_W'(i));
    assign cell_ctl[i].remove = remove_ok;

    bswc_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .elem_i  (elem),
      .next_i  (next_val),
      .valid_i (cell_valid[i]),
      .ctl_i   (cell_ctl[i]),
      .prefix_i(prefix[i]),
      .value_o (cell_val[i]),
      .match_o (cell_match[i]),
      .prefix_o(prefix[i+1])
    );
  end

  assign member    = |cell_match;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign add_ok    = accept && (func == FUNC_ADD) && !full && !member;
  assign remove_ok = accept && (func == FUNC_REMOVE) && member;

  assign idx_ext = CMP_W'(in_index);
  assign idx_ok  = (idx_ext < CMP_W'(count_r)) && (idx_ext < CMP_W'(CAPACITY));

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (idx_ext == CMP_W'(i)) begin
        rd_sel = cell_val[i];
      end
    end
  end

  assign rd_ext = 64'(rd_sel);

  always_comb begin
    status     = ST_OK;
    read_value = '0;
    count_nxt  = count_r;
    unique case (func)
      FUNC_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else if (member) begin
          status = ST_DUP;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (!member) begin
          status = ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FUNC_MEMBER: begin
      end
      FUNC_READ: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else begin
          read_value = rd_ext[ELEM_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status;
      member_r      <= member;
      entry_count_r <= COUNT_W'(count_nxt);
      read_value_r  <= read_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_was_member  = member_r;
  assign out_entry_count = entry_count_r;
  assign out_read_value  = read_value_r;

endmodule
